// ----- src/bwt4_pkg.sv -----
package bwt4_pkg;

   localparam int unsigned DEF_MAX_VERTICES  = 4096;
   localparam int unsigned DEF_SLOTS         = 4;
   localparam int unsigned DEF_BONE_ID_BITS  = 8;

   localparam int unsigned WEIGHT_BITS = 17;
   localparam int unsigned BONE_BITS   = 8;
   localparam int unsigned VERTEX_BITS = 16;
   localparam int unsigned LIMIT_BITS  = 13;
   localparam int unsigned OUT_SLOTS   = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [WEIGHT_BITS-1:0] ONE_Q16        = 17'd65536;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET    = 13'd4096;
   localparam logic [WEIGHT_BITS-1:0] MIN_WEIGHT_RST = 17'd66;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_VERTEX_LIMIT = 1'b0,
      CSR_MIN_WEIGHT   = 1'b1
   } bwt4_csr_index_type;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_READ    = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_UNKNOWN = 2'd3
   } bwt4_req_code_type;

   typedef enum logic [2:0] {
      STS_PLACED     = 3'd0,
      STS_REPLACED   = 3'd1,
      STS_DISCARDED  = 3'd2,
      STS_BELOW      = 3'd3,
      STS_BAD_VERTEX = 3'd4,
      STS_READ_OK    = 3'd5,
      STS_CLEARED    = 3'd6,
      STS_SPARE      = 3'd7
   } bwt4_status_type;

   // what the back end has to do with a queued item
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_REPLY = 2'd3
   } bwt4_op_type;

   typedef struct packed {
      bwt4_req_code_type        req_type;
      logic [VERTEX_BITS-1:0]   vertex_id;
      logic [BONE_BITS-1:0]     bone_id;
      logic [WEIGHT_BITS-1:0]   weight_in;
   } bwt4_req_item_type;

   typedef struct packed {
      bwt4_status_type          status;
      logic [WEIGHT_BITS-1:0]   norm_weight0;
      logic [WEIGHT_BITS-1:0]   norm_weight1;
      logic [WEIGHT_BITS-1:0]   norm_weight2;
      logic [WEIGHT_BITS-1:0]   norm_weight3;
      logic [BONE_BITS-1:0]     slot_bone0;
      logic [BONE_BITS-1:0]     slot_bone1;
      logic [BONE_BITS-1:0]     slot_bone2;
      logic [BONE_BITS-1:0]     slot_bone3;
   } bwt4_rsp_item_type;

   typedef struct packed {
      bwt4_op_type              op;
      bwt4_status_type          status;
      logic [VERTEX_BITS-1:0]   vertex;
      logic [BONE_BITS-1:0]     bone;
      logic [WEIGHT_BITS-1:0]   weight;
   } bwt4_cmd_type;

endpackage

// ----- src/bone_weight_top4_accumulator.sv -----
// Bone weight table: keeps up to SLOTS_PER_VERTEX bone influences per vertex.
// Request channel (req_push/req_full): add, read or clear one vertex. Each
// item gives exactly one result on the response channel (rsp_empty/rsp_pop),
// in request order. The csr channel sets vertex_limit (index 0) and
// min_weight (index 1); it is always ready.
// A front end checks the vertex range, saturates the weight and applies the
// threshold, then places the item in a two-entry queue. The back end fetches
// the vertex row from the table memory and carries the item out.
// A read normalizes min(SLOTS_PER_VERTEX, 4) slots with the shared restoring
// divider, which makes one quotient bit a cycle. The back end takes one item
// at a time and pops the next from the queue only after replying.
// After reset the back end clears the table one row a cycle; req_full stays
// high until every row is cleared. Configuration writes are taken throughout.
// A result waits in the output register until popped; meanwhile the queue
// keeps taking items and the back end stalls at its reply step.
module bone_weight_top4_accumulator #(
   parameter int unsigned MAX_VERTICES     = bwt4_pkg::DEF_MAX_VERTICES,
   parameter int unsigned SLOTS_PER_VERTEX = bwt4_pkg::DEF_SLOTS,
   parameter int unsigned BONE_ID_BITS     = bwt4_pkg::DEF_BONE_ID_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  bwt4_pkg::bwt4_req_item_type req_item,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output bwt4_pkg::bwt4_rsp_item_type rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  bwt4_pkg::bwt4_csr_index_type csr_index,
   input  logic [bwt4_pkg::WEIGHT_BITS-1:0] csr_data
);
   import bwt4_pkg::*;

   logic         wiping;
   logic         q_push, q_full, q_pop, q_empty;
   bwt4_cmd_type q_data, q_head;

   bwt4_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .wiping    (wiping),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   bwt4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   bwt4_back #(
      .MAX_VERTICES     (MAX_VERTICES),
      .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX),
      .BONE_ID_BITS     (BONE_ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wiping    (wiping),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- src/bwt4_queue.sv -----
module bwt4_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bwt4_pkg::bwt4_cmd_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output bwt4_pkg::bwt4_cmd_type head
);
   import bwt4_pkg::*;

   localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   bwt4_cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]          count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == (PtrBits+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/bwt4_front.sv -----
module bwt4_front #(
   parameter int unsigned MAX_VERTICES = bwt4_pkg::DEF_MAX_VERTICES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  bwt4_pkg::bwt4_req_item_type req_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  bwt4_pkg::bwt4_csr_index_type csr_index,
   input  logic [bwt4_pkg::WEIGHT_BITS-1:0] csr_data,
   input  logic                      wiping,
   input  logic                      q_full,
   output logic                      q_push,
   output bwt4_pkg::bwt4_cmd_type    q_data
);
   import bwt4_pkg::*;

   logic [LIMIT_BITS-1:0]  limit_ff;
   logic [WEIGHT_BITS-1:0] min_weight_ff;
   logic                   vertex_ok;
   logic [WEIGHT_BITS-1:0] w_sat;

   assign csr_ready = 1'b1;
   assign req_full  = q_full || wiping;
   assign q_push    = req_push && !req_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         min_weight_ff <= MIN_WEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_LIMIT: limit_ff      <= csr_data[LIMIT_BITS-1:0];
            CSR_MIN_WEIGHT:   min_weight_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // classify the item; checks that need no table access are settled here
   always_comb begin
      vertex_ok = ({1'b0, req_item.vertex_id} < {4'b0, limit_ff}) &&
                  ({1'b0, req_item.vertex_id} < 17'(MAX_VERTICES));
      w_sat     = (req_item.weight_in > ONE_Q16) ? ONE_Q16 : req_item.weight_in;
      q_data.vertex = req_item.vertex_id;
      q_data.bone   = req_item.bone_id;
      q_data.weight = w_sat;
      q_data.op     = OP_REPLY;
      q_data.status = STS_DISCARDED;
      priority if (req_item.req_type == REQ_UNKNOWN) begin
         q_data.status = STS_DISCARDED;
      end else if (!vertex_ok) begin
         q_data.status = STS_BAD_VERTEX;
      end else if (req_item.req_type == REQ_ADD) begin
         if (w_sat < min_weight_ff) begin
            q_data.status = STS_BELOW;
         end else begin
            q_data.op = OP_ADD;
         end
      end else if (req_item.req_type == REQ_READ) begin
         q_data.op     = OP_READ;
         q_data.status = STS_READ_OK;
      end else begin
         q_data.op     = OP_CLEAR;
         q_data.status = STS_CLEARED;
      end
   end

endmodule

// ----- src/bwt4_back.sv -----
module bwt4_back #(
   parameter int unsigned MAX_VERTICES     = bwt4_pkg::DEF_MAX_VERTICES,
   parameter int unsigned SLOTS_PER_VERTEX = bwt4_pkg::DEF_SLOTS,
   parameter int unsigned BONE_ID_BITS     = bwt4_pkg::DEF_BONE_ID_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      wiping,
   input  logic                      q_empty,
   input  bwt4_pkg::bwt4_cmd_type    q_head,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output bwt4_pkg::bwt4_rsp_item_type rsp_item
);
   import bwt4_pkg::*;

   localparam int unsigned AddrBits = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned SlotBits = (SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 1;
   localparam int unsigned SumBits  = WEIGHT_BITS +
                                      ((SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 0);
   localparam int unsigned BoneBits = (BONE_ID_BITS > BONE_BITS) ? BONE_BITS : BONE_ID_BITS;
   localparam int unsigned OutSlots = (SLOTS_PER_VERTEX > OUT_SLOTS) ? OUT_SLOTS
                                                                     : SLOTS_PER_VERTEX;
   localparam int unsigned RowW     = SLOTS_PER_VERTEX * WEIGHT_BITS;
   localparam int unsigned RowB     = SLOTS_PER_VERTEX * BoneBits;
   localparam int unsigned DivSteps = 16;

   typedef enum logic [4:0] {
      S_WIPE   = 5'b00001,
      S_IDLE   = 5'b00010,
      S_EXEC   = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_REPLY  = 5'b10000
   } bwt4_back_state_type;

   // table storage, one row per vertex
   logic [RowW-1:0]        wmem [MAX_VERTICES];
   logic [RowB-1:0]        bmem [MAX_VERTICES];
   logic [RowW-1:0]        rdw_ff;
   logic [RowB-1:0]        rdb_ff;

   bwt4_back_state_type    state_ff, state_in;
   logic [AddrBits-1:0]    wipe_ff, wipe_in;
   bwt4_cmd_type           cmd_ff, cmd_in;
   logic [SumBits-1:0]     sum_ff, sum_in;
   logic [SumBits-1:0]     rem_ff, rem_in;
   logic [WEIGHT_BITS-1:0] quo_ff, quo_in;
   logic [4:0]             step_ff, step_in;
   logic [SlotBits-1:0]    slot_ff, slot_in;
   logic [WEIGHT_BITS-1:0] norm_ff [OUT_SLOTS];
   logic [WEIGHT_BITS-1:0] norm_in [OUT_SLOTS];
   logic [BONE_BITS-1:0]   obone_ff [OUT_SLOTS];
   logic [BONE_BITS-1:0]   obone_in [OUT_SLOTS];
   bwt4_status_type        status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bwt4_rsp_item_type      rsp_ff, rsp_in;

   logic                   rd_en;
   logic [AddrBits-1:0]    rd_addr;
   logic                   wr_en;
   logic [AddrBits-1:0]    wr_addr;
   logic [RowW-1:0]        wr_w;
   logic [RowB-1:0]        wr_b;

   logic [WEIGHT_BITS-1:0] wt [SLOTS_PER_VERTEX];
   logic [SlotBits-1:0]    empty_idx, lo_idx, tgt_idx;
   logic                   found_empty;
   logic [WEIGHT_BITS-1:0] lo_w;
   logic [SumBits-1:0]     sum_c;
   logic [SumBits-1:0]     w_ext, rem_sub;
   logic [SumBits:0]       rem2;
   logic                   ge;
   logic                   rsp_free;

   assign wiping    = (state_ff == S_WIPE);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign rd_en     = q_pop;
   assign rd_addr   = q_head.vertex[AddrBits-1:0];

   // unpack the fetched row
   always_comb begin
      for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
         wt[s] = rdw_ff[s*WEIGHT_BITS +: WEIGHT_BITS];
      end
   end

   // first empty slot, smallest slot (lowest on a tie) and the row sum
   always_comb begin
      found_empty = 1'b0;
      empty_idx   = '0;
      for (int s = SLOTS_PER_VERTEX-1; s >= 0; s--) begin
         if (wt[s] == '0) begin
            found_empty = 1'b1;
            empty_idx   = SlotBits'(s);
         end
      end
      lo_w   = wt[0];
      lo_idx = '0;
      for (int s = 1; s < SLOTS_PER_VERTEX; s++) begin
         if (wt[s] < lo_w) begin
            lo_w   = wt[s];
            lo_idx = SlotBits'(s);
         end
      end
      tgt_idx = found_empty ? empty_idx : lo_idx;
      sum_c   = '0;
      for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
         sum_c = sum_c + SumBits'(wt[s]);
      end
   end

   // one restoring division step, shared by all slots
   always_comb begin
      w_ext   = SumBits'(wt[slot_ff]);
      rem2    = {rem_ff, 1'b0};
      if (step_ff == '0) begin
         ge      = (w_ext >= sum_ff);
         rem_sub = w_ext - sum_ff;
      end else begin
         ge      = (rem2 >= {1'b0, sum_ff});
         rem_sub = SumBits'(rem2 - {1'b0, sum_ff});
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wipe_in      = wipe_ff;
      cmd_in       = cmd_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      for (int k = 0; k < OUT_SLOTS; k++) begin
         norm_in[k]  = norm_ff[k];
         obone_in[k] = obone_ff[k];
      end
      wr_en   = 1'b0;
      wr_addr = cmd_ff.vertex[AddrBits-1:0];
      wr_w    = rdw_ff;
      wr_b    = rdb_ff;

      unique case (state_ff)
         S_WIPE: begin
            wr_en   = 1'b1;
            wr_addr = wipe_ff;
            wr_w    = '0;
            wr_b    = '0;
            wipe_in = wipe_ff + 1'b1;
            if (wipe_ff == AddrBits'(MAX_VERTICES-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               cmd_in    = q_head;
               status_in = q_head.status;
               for (int k = 0; k < OUT_SLOTS; k++) begin
                  norm_in[k]  = '0;
                  obone_in[k] = '0;
               end
               state_in = (q_head.op == OP_REPLY) ? S_REPLY : S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff.op)
               OP_ADD: begin
                  if (found_empty || (cmd_ff.weight > lo_w)) begin
                     wr_en = 1'b1;
                     wr_w[tgt_idx*WEIGHT_BITS +: WEIGHT_BITS] = cmd_ff.weight;
                     wr_b[tgt_idx*BoneBits +: BoneBits]       = cmd_ff.bone[BoneBits-1:0];
                     status_in = found_empty ? STS_PLACED : STS_REPLACED;
                  end else begin
                     status_in = STS_DISCARDED;
                  end
                  state_in = S_REPLY;
               end
               OP_CLEAR: begin
                  wr_en    = 1'b1;
                  wr_w     = '0;
                  wr_b     = '0;
                  state_in = S_REPLY;
               end
               OP_READ: begin
                  for (int k = 0; k < OutSlots; k++) begin
                     obone_in[k] = BONE_BITS'(rdb_ff[k*BoneBits +: BoneBits]);
                  end
                  sum_in  = sum_c;
                  slot_in = '0;
                  step_in = '0;
                  if (sum_c == '0) begin
                     norm_in[0]  = ONE_Q16;
                     obone_in[0] = '0;
                     state_in    = S_REPLY;
                  end else begin
                     state_in = S_DIVIDE;
                  end
               end
               default: state_in = S_REPLY;
            endcase
         end
         S_DIVIDE: begin
            if (step_ff == '0) begin
               quo_in = {{(WEIGHT_BITS-1){1'b0}}, ge};
               rem_in = ge ? rem_sub : w_ext;
            end else begin
               quo_in = {quo_ff[WEIGHT_BITS-2:0], ge};
               rem_in = ge ? rem_sub : rem2[SumBits-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(DivSteps)) begin
               for (int k = 0; k < OutSlots; k++) begin
                  if (SlotBits'(k) == slot_ff) begin
                     norm_in[k] = quo_in;
                  end
               end
               step_in = '0;
               slot_in = slot_ff + 1'b1;
               if (slot_ff == SlotBits'(OutSlots-1)) begin
                  state_in = S_REPLY;
               end
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.norm_weight0 = norm_ff[0];
               rsp_in.norm_weight1 = norm_ff[1];
               rsp_in.norm_weight2 = norm_ff[2];
               rsp_in.norm_weight3 = norm_ff[3];
               rsp_in.slot_bone0   = obone_ff[0];
               rsp_in.slot_bone1   = obone_ff[1];
               rsp_in.slot_bone2   = obone_ff[2];
               rsp_in.slot_bone3   = obone_ff[3];
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sum_ff    <= sum_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      for (int k = 0; k < OUT_SLOTS; k++) begin
         norm_ff[k]  <= norm_in[k];
         obone_ff[k] <= obone_in[k];
      end
   end

   // table memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_w;
         bmem[wr_addr] <= wr_b;
      end
      if (rd_en) begin
         rdw_ff <= wmem[rd_addr];
         rdb_ff <= bmem[rd_addr];
      end
   end

endmodule
